// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// Every macro samples on clk and stays quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds at every clock edge outside reset.
`define TPCQ_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// The condition in one cycle implies the property in the next cycle.
`define TPCQ_ASSERT_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/core/tpcq_pkg.sv =====
package tpcq_pkg;

	// Default sizes.
	localparam int QUEUE_DEPTH_DEF     = 8;
	localparam int NEXT_INDEX_BITS_DEF = 8;
	localparam int QTY_BITS_DEF        = 8;

	// Fixed field widths of the channels.
	localparam int TIME_W = 64;
	localparam int NEXT_W = 8;
	localparam int QTY_W  = 8;
	localparam int IDX_W  = 4;
	localparam int CODE_W = 2;

	// Actions.
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	// Queue codes, ordered by priority.
	localparam logic [CODE_W-1:0] Q_LO = 2'd0;
	localparam logic [CODE_W-1:0] Q_HI = 2'd1;
	localparam logic [CODE_W-1:0] Q_IL = 2'd2;

	// Command types.
	localparam logic [CODE_W-1:0] CMD_NOP   = 2'd0;
	localparam logic [CODE_W-1:0] CMD_FLOW  = 2'd1;
	localparam logic [CODE_W-1:0] CMD_FLUSH = 2'd2;

	// Result status codes.
	localparam logic [CODE_W-1:0] STAT_PUSHED = 2'd0;
	localparam logic [CODE_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [CODE_W-1:0] STAT_NONE   = 2'd2;
	localparam logic [CODE_W-1:0] STAT_SERVED = 2'd3;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PUSH,
		S_PROBE,
		S_TEST,
		S_SERVE,
		S_DONE
	} state_t;

	// Pointer updates requested by the sequencer.
	typedef struct packed {
		logic push;
		logic pop;
		logic flush_hi;
		logic flush_lo;
	} ptr_op_t;

endpackage

// ===== rtl/core/tpcq_chan_if.sv =====
// Command channel into the queues.
interface tpcq_cmd_if;
	import tpcq_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [CODE_W-1:0] queue_select;
	logic [CODE_W-1:0] cmd_type;
	logic [NEXT_W-1:0] next_index;
	logic [QTY_W-1:0]  quantity;
	logic              flush_hi;
	logic [IDX_W-1:0]  flush_hi_index;
	logic              flush_lo;
	logic [IDX_W-1:0]  flush_lo_index;
	logic [TIME_W-1:0] due_time;
	logic [TIME_W-1:0] now_time;
	logic [NEXT_W-1:0] current_next;

	modport source (
		output valid, action, queue_select, cmd_type, next_index, quantity,
			flush_hi, flush_hi_index, flush_lo, flush_lo_index, due_time, now_time,
			current_next,
		input ready
	);

	modport sink (
		input valid, action, queue_select, cmd_type, next_index, quantity,
			flush_hi, flush_hi_index, flush_lo, flush_lo_index, due_time, now_time,
			current_next,
		output ready
	);
endinterface

// Result channel out of the queues.
interface tpcq_rsp_if;
	import tpcq_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] status;
	logic [CODE_W-1:0] served_queue;
	logic [CODE_W-1:0] served_type;
	logic [NEXT_W-1:0] next_out;
	logic [QTY_W-1:0]  remaining_quantity;
	logic [IDX_W-1:0]  write_index;
	logic [IDX_W-1:0]  read_index;

	modport source (
		output valid, status, served_queue, served_type, next_out,
			remaining_quantity, write_index, read_index,
		input ready
	);

	modport sink (
		input valid, status, served_queue, served_type, next_out,
			remaining_quantity, write_index, read_index,
		output ready
	);
endinterface

// ===== rtl/core/tpcq_mem.sv =====
module tpcq_mem #(
	parameter int DEPTH = 24,
	parameter int DATA_W = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/core/tpcq_ptrs.sv =====
module tpcq_ptrs #(
	parameter int QUEUE_DEPTH = tpcq_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = $clog2(QUEUE_DEPTH) + 1,
	localparam int ADDR_W = $clog2(3 * QUEUE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tpcq_pkg::CODE_W-1:0] qsel,
	input  tpcq_pkg::ptr_op_t          op,
	input  logic [tpcq_pkg::IDX_W-1:0] flush_hi_index,
	input  logic [tpcq_pkg::IDX_W-1:0] flush_lo_index,
	output logic [PTR_W-1:0]           wptr,
	output logic [PTR_W-1:0]           rptr,
	output logic                       empty,
	output logic                       full,
	output logic [ADDR_W-1:0]          wslot,
	output logic [ADDR_W-1:0]          rslot
);
	import tpcq_pkg::*;

	localparam int SPAN = 2 * QUEUE_DEPTH;
	localparam int WRAP_W = 10;

	logic [PTR_W-1:0] wptr_q [3];
	logic [PTR_W-1:0] rptr_q [3];
	logic [ADDR_W-1:0] base;
	logic [PTR_W-1:0] wdist;

	// Next pointer value, wrapping at twice the depth.
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(SPAN - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	// Position of a pointer inside its ring.
	function automatic logic [PTR_W-1:0] ptr_pos(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p >= PTR_W'(QUEUE_DEPTH)) begin
			r = p - PTR_W'(QUEUE_DEPTH);
		end else begin
			r = p;
		end
		return r;
	endfunction

	// Reduce a flush index into the pointer range by repeated subtraction.
	function automatic logic [PTR_W-1:0] idx_wrap(input logic [IDX_W-1:0] idx);
		logic [WRAP_W-1:0] v;
		v = WRAP_W'(idx);
		for (int i = 0; i < 3; i++) begin
			if (v >= WRAP_W'(SPAN)) begin
				v = v - WRAP_W'(SPAN);
			end
		end
		return PTR_W'(v);
	endfunction

	// View of the selected queue.
	always_comb begin
		wptr = wptr_q[qsel];
		rptr = rptr_q[qsel];
		case (qsel)
			Q_LO: base = '0;
			Q_HI: base = ADDR_W'(QUEUE_DEPTH);
			default: base = ADDR_W'(2 * QUEUE_DEPTH);
		endcase
		wslot = base + ADDR_W'(ptr_pos(wptr));
		rslot = base + ADDR_W'(ptr_pos(rptr));
		empty = (wptr == rptr);
		wdist = (wptr >= rptr) ? (wptr - rptr) : (rptr - wptr);
		full = (wdist == PTR_W'(QUEUE_DEPTH));
	end

	// Pointer updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				wptr_q[i] <= '0;
				rptr_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (op.push && qsel == CODE_W'(i)) begin
					wptr_q[i] <= ptr_inc(wptr_q[i]);
				end
				if (op.pop && qsel == CODE_W'(i)) begin
					rptr_q[i] <= ptr_inc(rptr_q[i]);
				end
			end
			if (op.flush_hi) begin
				rptr_q[1] <= idx_wrap(flush_hi_index);
			end
			if (op.flush_lo) begin
				rptr_q[0] <= idx_wrap(flush_lo_index);
			end
		end
	end
endmodule

// ===== rtl/core/timed_priority_command_queues.sv =====
// Channel  Modport  Carries
// cmd      sink     push or check request, one beat per request
// rsp      source   one result beat per request
//
// A push passes through the push step, then the done step. A check probes the queues
// from IL down to LO: an empty queue is passed over, a non-empty one gets a registered
// head read and then the shared time compare, and a due head is then served.
// arst_n clears all queue pointers and the result valid flag; entry memory is not reset.
// A new request is taken while a finished result waits on rsp; the next result waits
// for rsp to free its register.
`include "assert_macros.svh"

module timed_priority_command_queues #(
	parameter int QUEUE_DEPTH = tpcq_pkg::QUEUE_DEPTH_DEF,
	parameter int NEXT_INDEX_BITS = tpcq_pkg::NEXT_INDEX_BITS_DEF,
	parameter int QTY_BITS = tpcq_pkg::QTY_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tpcq_cmd_if.sink   cmd,
	tpcq_rsp_if.source rsp
);
	import tpcq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH) + 1;
	localparam int SLOTS = 3 * QUEUE_DEPTH;
	localparam int ADDR_W = $clog2(SLOTS);
	localparam int NB = (NEXT_INDEX_BITS < NEXT_W) ? NEXT_INDEX_BITS : NEXT_W;

	// Entry layout, least significant field first.
	localparam int FLO_IDX_LSB = 0;
	localparam int FLO_BIT = IDX_W;
	localparam int FHI_IDX_LSB = IDX_W + 1;
	localparam int FHI_BIT = 2 * IDX_W + 1;
	localparam int QTY_LSB = 2 * IDX_W + 2;
	localparam int NEXT_LSB = QTY_LSB + QTY_BITS;
	localparam int TYPE_LSB = NEXT_LSB + NB;
	localparam int TIME_LSB = TYPE_LSB + CODE_W;
	localparam int ENTRY_W = TIME_LSB + TIME_W;

	state_t state_q, state_d;
	logic [CODE_W-1:0] qsel_q, qsel_d;

	// Request held while it is worked on.
	logic [CODE_W-1:0] cmd_type_q;
	logic [NB-1:0] next_index_q;
	logic [QTY_BITS-1:0] quantity_q;
	logic flush_hi_q;
	logic [IDX_W-1:0] flush_hi_index_q;
	logic flush_lo_q;
	logic [IDX_W-1:0] flush_lo_index_q;
	logic [TIME_W-1:0] due_time_q;
	logic [TIME_W-1:0] now_time_q;
	logic [NEXT_W-1:0] current_next_q;

	// Result fields built by the sequencer.
	logic [CODE_W-1:0] res_status_q, res_status_d;
	logic [CODE_W-1:0] res_type_q, res_type_d;
	logic [NEXT_W-1:0] res_next_q, res_next_d;
	logic [QTY_W-1:0] res_rem_q, res_rem_d;

	// Output register.
	logic rsp_valid_q;
	logic [CODE_W-1:0] out_status_q, out_queue_q, out_type_q;
	logic [NEXT_W-1:0] out_next_q;
	logic [QTY_W-1:0] out_rem_q;
	logic [IDX_W-1:0] out_widx_q, out_ridx_q;

	logic cmd_acc;
	logic load_out;
	ptr_op_t ptr_op;
	logic [PTR_W-1:0] view_wptr, view_rptr;
	logic view_empty, view_full;
	logic [ADDR_W-1:0] view_wslot, view_rslot;

	logic mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata, push_entry, wb_entry;

	logic [TIME_W-1:0] rd_time;
	logic [CODE_W-1:0] rd_type;
	logic [NB-1:0] rd_next;
	logic [QTY_BITS-1:0] rd_qty, qty_eff, qty_dec;
	logic rd_fhi, rd_flo;
	logic head_due, pop_head;

	tpcq_ptrs #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ptrs (
		.clk(clk),
		.arst_n(arst_n),
		.qsel(qsel_q),
		.op(ptr_op),
		.flush_hi_index(mem_rdata[FHI_IDX_LSB +: IDX_W]),
		.flush_lo_index(mem_rdata[FLO_IDX_LSB +: IDX_W]),
		.wptr(view_wptr),
		.rptr(view_rptr),
		.empty(view_empty),
		.full(view_full),
		.wslot(view_wslot),
		.rslot(view_rslot)
	);

	tpcq_mem #(
		.DEPTH(SLOTS),
		.DATA_W(ENTRY_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(view_rslot),
		.rdata(mem_rdata)
	);

	assign cmd_acc = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);

	// Fields of the head entry read from memory.
	assign rd_time = mem_rdata[TIME_LSB +: TIME_W];
	assign rd_type = mem_rdata[TYPE_LSB +: CODE_W];
	assign rd_next = mem_rdata[NEXT_LSB +: NB];
	assign rd_qty = mem_rdata[QTY_LSB +: QTY_BITS];
	assign rd_fhi = mem_rdata[FHI_BIT];
	assign rd_flo = mem_rdata[FLO_BIT];

	// The shared time compare, applied to one queue head at a time.
	assign head_due = (rd_time <= now_time_q);

	// Serving: a flush always pops, otherwise the quantity decides.
	assign qty_eff = (rd_type == CMD_FLUSH) ? QTY_BITS'(1) : rd_qty;
	assign pop_head = (qty_eff <= QTY_BITS'(1));
	assign qty_dec = qty_eff - QTY_BITS'(1);

	assign push_entry = {due_time_q, cmd_type_q, next_index_q, quantity_q,
		flush_hi_q, flush_hi_index_q, flush_lo_q, flush_lo_index_q};
	assign wb_entry = {mem_rdata[ENTRY_W-1:NEXT_LSB], qty_dec, mem_rdata[QTY_LSB-1:0]};

	// Capture of an accepted request beat.
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			cmd_type_q <= (cmd.cmd_type > CMD_FLUSH) ? CMD_NOP : cmd.cmd_type;
			next_index_q <= cmd.next_index[NB-1:0];
			quantity_q <= cmd.quantity[QTY_BITS-1:0];
			flush_hi_q <= cmd.flush_hi;
			flush_hi_index_q <= cmd.flush_hi_index;
			flush_lo_q <= cmd.flush_lo;
			flush_lo_index_q <= cmd.flush_lo_index;
			due_time_q <= cmd.due_time;
			now_time_q <= cmd.now_time;
			current_next_q <= cmd.current_next;
		end
	end

	// Sequencer state and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			qsel_q <= Q_LO;
		end else begin
			state_q <= state_d;
			qsel_q <= qsel_d;
		end
	end

	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_type_q <= res_type_d;
		res_next_q <= res_next_d;
		res_rem_q <= res_rem_d;
	end

	// Sequencer: next state, pointer updates and memory access.
	always_comb begin
		state_d = state_q;
		qsel_d = qsel_q;
		ptr_op = '0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_waddr = view_wslot;
		mem_wdata = push_entry;
		load_out = 1'b0;
		res_status_d = res_status_q;
		res_type_d = res_type_q;
		res_next_d = res_next_q;
		res_rem_d = res_rem_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_acc) begin
					if (cmd.action == ACT_CHECK) begin
						qsel_d = Q_IL;
						state_d = S_PROBE;
					end else begin
						qsel_d = (cmd.queue_select > Q_IL) ? Q_IL : cmd.queue_select;
						state_d = S_PUSH;
					end
				end
			end
			S_PUSH: begin
				res_type_d = CMD_NOP;
				res_next_d = '0;
				res_rem_d = '0;
				if (view_full) begin
					res_status_d = STAT_FULL;
				end else begin
					res_status_d = STAT_PUSHED;
					mem_we = 1'b1;
					ptr_op.push = 1'b1;
				end
				state_d = S_DONE;
			end
			S_PROBE: begin
				if (!view_empty) begin
					mem_re = 1'b1;
					state_d = S_TEST;
				end else if (qsel_q == Q_LO) begin
					res_status_d = STAT_NONE;
					res_type_d = CMD_NOP;
					res_next_d = current_next_q;
					res_rem_d = '0;
					state_d = S_DONE;
				end else begin
					qsel_d = qsel_q - CODE_W'(1);
				end
			end
			S_TEST: begin
				if (head_due) begin
					state_d = S_SERVE;
				end else if (qsel_q == Q_LO) begin
					res_status_d = STAT_NONE;
					res_type_d = CMD_NOP;
					res_next_d = current_next_q;
					res_rem_d = '0;
					state_d = S_DONE;
				end else begin
					qsel_d = qsel_q - CODE_W'(1);
					state_d = S_PROBE;
				end
			end
			S_SERVE: begin
				res_status_d = STAT_SERVED;
				res_type_d = rd_type;
				res_next_d = (rd_type == CMD_FLOW) ? NEXT_W'(rd_next) : current_next_q;
				if (rd_type == CMD_FLUSH) begin
					ptr_op.flush_hi = (qsel_q == Q_IL) && rd_fhi;
					ptr_op.flush_lo = (qsel_q != Q_LO) && rd_flo;
				end
				if (pop_head) begin
					ptr_op.pop = 1'b1;
					res_rem_d = '0;
				end else begin
					mem_we = 1'b1;
					mem_waddr = view_rslot;
					mem_wdata = wb_entry;
					res_rem_d = QTY_W'(qty_dec);
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result register: loaded from the finished step, held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_queue_q <= qsel_q;
			out_type_q <= res_type_q;
			out_next_q <= res_next_q;
			out_rem_q <= res_rem_q;
			out_widx_q <= IDX_W'(view_wptr);
			out_ridx_q <= IDX_W'(view_rptr);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.served_queue = out_queue_q;
	assign rsp.served_type = out_type_q;
	assign rsp.next_out = out_next_q;
	assign rsp.remaining_quantity = out_rem_q;
	assign rsp.write_index = out_widx_q;
	assign rsp.read_index = out_ridx_q;

	// Checks on the sequencer.
	`TPCQ_ASSERT(a_push_not_full, ptr_op.push |-> !view_full, "push into a full queue")
	`TPCQ_ASSERT(a_pop_not_empty, ptr_op.pop |-> !view_empty, "pop from an empty queue")
	`TPCQ_ASSERT_NEXT(a_read_then_test, mem_re, state_q == S_TEST, "head read not tested")
	`TPCQ_ASSERT(a_wb_qty, (mem_we && state_q == S_SERVE) |-> !pop_head, "spent head kept")
endmodule
